[rtl/tgapsd_pkg.sv]
// ----------------------------------------------------------------------------
// tgapsd_pkg
// Types and constants shared by the TGA pixel stream decoder files.
// ----------------------------------------------------------------------------
package tgapsd_pkg;

    // Largest image side in pixels; bigger register values saturate here
    localparam logic [11:0] MAX_DIM = 12'd2048;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RLE_ENABLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_DOWN     = 3'd4;

    // Packet header fields
    localparam logic [7:0] HDR_RUN_BIT = 8'h80;
    localparam logic [7:0] HDR_CNT_MASK = 8'h7F;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // Sticky flag bit positions
    localparam int SEEN_TRANSP = 0;
    localparam int SEEN_TRANSL = 1;
    localparam int SEEN_SOLID  = 2;

    typedef enum logic [1:0] {
        FMT_INDEX8 = 2'd0,
        FMT_RGB555 = 2'd1,
        FMT_BGR24  = 2'd2,
        FMT_BGRA32 = 2'd3
    } t_pix_fmt;

    typedef struct packed {
        t_pix_fmt    pixel_format;
        logic        rle_enable;
        logic [11:0] image_width;
        logic [11:0] image_height;
        logic        top_down;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  index_value;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  repeat_count;
        logic [10:0] row_out;
        logic [10:0] column_out;
        logic        frame_done;
        logic        has_transparent;
        logic        has_translucent;
        logic        has_solid;
    } t_out_word;

    // Zero acts as one, anything past the limit acts as the limit
    function automatic logic [11:0] clamp_dim(input logic [11:0] v);
        logic [11:0] res;
        begin
            if (v == 12'd0) begin
                res = 12'd1;
            end else if (v > MAX_DIM) begin
                res = MAX_DIM;
            end else begin
                res = v;
            end
            return res;
        end
    endfunction

endpackage

[rtl/tgapsd_core.sv]
// ----------------------------------------------------------------------------
// tgapsd_core
// Per-byte decode state: packet headers, pixel assembly, row/column tracking
// and sticky alpha flags. One byte is consumed in each cycle that i_fire is high.
// ----------------------------------------------------------------------------
module tgapsd_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  tgapsd_pkg::t_in_word i_word,
    input  tgapsd_pkg::t_cfg     i_cfg,
    output logic                 o_res_valid,
    output tgapsd_pkg::t_out_word o_res
);

    logic        r_expect_hdr, n_expect_hdr;
    logic        r_is_run,     n_is_run;
    logic [7:0]  r_left,       n_left;
    logic [1:0]  r_byte_idx,   n_byte_idx;
    logic [31:0] r_asm,        n_asm;
    logic [11:0] r_col,        n_col;
    logic [11:0] r_row,        n_row;
    logic        r_finished,   n_finished;
    logic [2:0]  r_seen,       n_seen;

    logic [11:0] w_w;
    logic [11:0] w_h;

    assign w_w = tgapsd_pkg::clamp_dim(i_cfg.image_width);
    assign w_h = tgapsd_pkg::clamp_dim(i_cfg.image_height);

    always_comb begin
        logic        stop;
        logic [31:0] asm_new;
        logic [7:0]  rep;
        logic [11:0] room;
        logic [7:0]  idx, red, grn, blu, alp;
        logic [11:0] row;
        logic        done;
        logic [7:0]  b;

        n_expect_hdr = r_expect_hdr;
        n_is_run     = r_is_run;
        n_left       = r_left;
        n_byte_idx   = r_byte_idx;
        n_asm        = r_asm;
        n_col        = r_col;
        n_row        = r_row;
        n_finished   = r_finished;
        n_seen       = r_seen;
        o_res_valid  = 1'b0;
        o_res        = '0;
        stop    = 1'b0;
        asm_new = '0;
        rep     = 8'd1;
        room    = '0;
        idx     = '0;
        red     = '0;
        grn     = '0;
        blu     = '0;
        alp     = tgapsd_pkg::ALPHA_OPAQUE;
        row     = '0;
        done    = 1'b0;
        b       = i_word.data_byte;

        if (i_word.frame_start) begin
            n_expect_hdr = 1'b1;
            n_is_run     = 1'b0;
            n_left       = '0;
            n_byte_idx   = '0;
            n_asm        = '0;
            n_col        = '0;
            n_row        = '0;
            n_finished   = 1'b0;
            n_seen       = '0;
        end

        if (!n_finished) begin
            // close a full row once no packet still feeds it
            if (n_col >= w_w && (!i_cfg.rle_enable || n_expect_hdr)) begin
                n_col = '0;
                n_row = n_row + 12'd1;
                if (n_row >= w_h) begin
                    n_finished = 1'b1;
                    stop = 1'b1;
                end
            end

            if (!stop) begin
                if (i_cfg.rle_enable && n_expect_hdr) begin
                    n_is_run     = |(b & tgapsd_pkg::HDR_RUN_BIT);
                    n_left       = (b & tgapsd_pkg::HDR_CNT_MASK) + 8'd1;
                    n_expect_hdr = 1'b0;
                    n_byte_idx   = '0;
                    n_asm        = '0;
                end else begin
                    asm_new = n_asm | ({24'd0, b} << {n_byte_idx, 3'b000});
                    if (n_byte_idx < i_cfg.pixel_format) begin
                        n_asm      = asm_new;
                        n_byte_idx = n_byte_idx + 2'd1;
                    end else begin
                        if (i_cfg.rle_enable) begin
                            if (n_is_run) begin
                                rep    = n_left;
                                n_left = '0;
                            end else if (n_left != 8'd0) begin
                                n_left = n_left - 8'd1;
                            end
                            if (n_left == 8'd0) begin
                                n_expect_hdr = 1'b1;
                            end
                        end
                        if (rep == 8'd0) begin
                            rep = 8'd1;
                        end

                        case (i_cfg.pixel_format)
                            tgapsd_pkg::FMT_INDEX8: begin
                                idx = asm_new[7:0];
                            end
                            tgapsd_pkg::FMT_RGB555: begin
                                red = {asm_new[14:10], 3'b000};
                                grn = {asm_new[9:5], 3'b000};
                                blu = {asm_new[4:0], 3'b000};
                            end
                            tgapsd_pkg::FMT_BGR24: begin
                                blu = asm_new[7:0];
                                grn = asm_new[15:8];
                                red = asm_new[23:16];
                            end
                            default: begin
                                blu = asm_new[7:0];
                                grn = asm_new[15:8];
                                red = asm_new[23:16];
                                alp = asm_new[31:24];
                            end
                        endcase
                        n_byte_idx = '0;
                        n_asm      = '0;

                        // pixels past the row end are dropped
                        if (n_col < w_w) begin
                            room = w_w - n_col;
                            if ({4'd0, rep} > room) begin
                                rep = room[7:0];
                            end

                            if (i_cfg.pixel_format == tgapsd_pkg::FMT_INDEX8) begin
                                if (idx == 8'd0) begin
                                    n_seen[tgapsd_pkg::SEEN_TRANSP] = 1'b1;
                                end else begin
                                    n_seen[tgapsd_pkg::SEEN_SOLID] = 1'b1;
                                end
                            end else if (alp == 8'd0) begin
                                n_seen[tgapsd_pkg::SEEN_TRANSP] = 1'b1;
                            end else if (alp == tgapsd_pkg::ALPHA_OPAQUE) begin
                                n_seen[tgapsd_pkg::SEEN_SOLID] = 1'b1;
                            end else begin
                                n_seen[tgapsd_pkg::SEEN_TRANSL] = 1'b1;
                            end

                            if (i_cfg.top_down) begin
                                row = n_row;
                            end else if (n_row < w_h) begin
                                row = w_h - 12'd1 - n_row;
                            end else begin
                                row = '0;
                            end

                            done = ({1'b0, n_col} + {5'd0, rep} >= {1'b0, w_w}) &&
                                   ({1'b0, n_row} + 13'd1 >= {1'b0, w_h});

                            o_res_valid           = i_fire;
                            o_res.index_value     = idx;
                            o_res.red             = red;
                            o_res.green           = grn;
                            o_res.blue            = blu;
                            o_res.alpha           = alp;
                            o_res.repeat_count    = rep;
                            o_res.row_out         = row[10:0];
                            o_res.column_out      = n_col[10:0];
                            o_res.frame_done      = done;
                            o_res.has_transparent = done & n_seen[tgapsd_pkg::SEEN_TRANSP];
                            o_res.has_translucent = done & n_seen[tgapsd_pkg::SEEN_TRANSL];
                            o_res.has_solid       = done & n_seen[tgapsd_pkg::SEEN_SOLID];

                            n_col = n_col + {4'd0, rep};
                            if (done) begin
                                n_finished = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_hdr <= 1'b1;
            r_is_run     <= 1'b0;
            r_left       <= '0;
            r_byte_idx   <= '0;
            r_asm        <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_finished   <= 1'b0;
            r_seen       <= '0;
        end else if (i_fire) begin
            r_expect_hdr <= n_expect_hdr;
            r_is_run     <= n_is_run;
            r_left       <= n_left;
            r_byte_idx   <= n_byte_idx;
            r_asm        <= n_asm;
            r_col        <= n_col;
            r_row        <= n_row;
            r_finished   <= n_finished;
            r_seen       <= n_seen;
        end
    end

    // packet counts stay within a header's range
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 8'd128)
        else $error("packet pixel count out of range");

    a_rep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.repeat_count != 8'd0 && o_res.repeat_count <= 8'd128))
        else $error("repeat count out of range");

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.frame_done) |=> r_finished)
        else $error("frame not closed after last pixel");

    a_quiet_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_finished && !i_word.frame_start) |-> !o_res_valid)
        else $error("pixel emitted after frame end");

endmodule

[rtl/tga_pixel_stream_decoder.sv]
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder
// Decodes the pixel-data bytes of a TGA image into pixels with position.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the skid buffer is empty. A byte lands in an
// input register and is decoded from there by a single state update; a pixel
// that it completes goes to the output register, or to the skid buffer if the
// output register is stalled. The output register is backed by a one-word
// skid buffer, so input stall rises only when that buffer is also full. Raw
// or run-length packet data, formats 8-bit index, 16-bit 1-5-5-5, 24-bit BGR
// and 32-bit BGRA. Configuration registers take effect immediately and are
// meant to be written while idle.
module tga_pixel_stream_decoder (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wr_en,
    input  logic [tgapsd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tgapsd_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  tgapsd_pkg::t_in_word                    i_in_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output tgapsd_pkg::t_out_word                   o_out_data
);

    tgapsd_pkg::t_cfg      r_cfg;
    logic                  r_in_valid;
    tgapsd_pkg::t_in_word  r_in;
    logic                  r_out_valid;
    tgapsd_pkg::t_out_word r_out;
    logic                  r_skd_valid;
    tgapsd_pkg::t_out_word r_skd;

    logic                  w_fire;
    logic                  w_accept;
    logic                  w_out_take;
    logic                  w_res_valid;
    tgapsd_pkg::t_out_word w_res;

    // a full skid word blocks decode, since the byte might yield a pixel
    assign w_fire     = r_in_valid && !r_skd_valid;
    assign o_in_stall = r_in_valid && r_skd_valid;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_format <= tgapsd_pkg::FMT_BGR24;
            r_cfg.rle_enable   <= 1'b0;
            r_cfg.image_width  <= 12'd1;
            r_cfg.image_height <= 12'd1;
            r_cfg.top_down     <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tgapsd_pkg::CFG_PIXEL_FORMAT:
                    r_cfg.pixel_format <= tgapsd_pkg::t_pix_fmt'(i_cfg_wdata[1:0]);
                tgapsd_pkg::CFG_RLE_ENABLE:   r_cfg.rle_enable   <= i_cfg_wdata[0];
                tgapsd_pkg::CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_wdata;
                tgapsd_pkg::CFG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_wdata;
                tgapsd_pkg::CFG_TOP_DOWN:     r_cfg.top_down     <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
    end

    tgapsd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_word      (r_in),
        .i_cfg       (r_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (w_out_take) begin
                r_skd_valid <= 1'b0;
            end
        end else if (w_res_valid) begin
            if (!r_out_valid || w_out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skd_valid <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (w_out_take) begin
                r_out <= r_skd;
            end
        end else if (w_res_valid) begin
            if (!r_out_valid || w_out_take) begin
                r_out <= w_res;
            end else begin
                r_skd <= w_res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_no_fire_on_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> !w_res_valid)
        else $error("decode result with full skid buffer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output word changed");

endmodule
